FILE: hw/rtl/aart_pkg.sv
// Package for the alert acknowledge and retransmit table.
// Holds command, status and entry state codes, field widths and the entry record.
// No dependencies; imported by alert_ack_retransmit_table and its testbench.
package aart_pkg;

  // Fixed field widths of the ports.
  localparam int CMD_W   = 2;
  localparam int CLASS_W = 8;
  localparam int ID_W    = 64;
  localparam int TIME_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  localparam int SLOT_W  = 4;
  localparam int ST_W    = 2;

  // Table size default and the most results one command may carry.
  localparam int DEFAULT_DEPTH = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int RES_W         = $clog2(MAX_RESULTS + 1);

  // Reset value of the acknowledge timeout register.
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(1000);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_RAISE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ACK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] RES_OK       = 2'd0;
  localparam logic [STAT_W-1:0] RES_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] RES_NOTFOUND = 2'd2;

  // Entry state codes.
  localparam logic [ST_W-1:0] ST_NEW     = 2'd0;
  localparam logic [ST_W-1:0] ST_WAIT    = 2'd1;
  localparam logic [ST_W-1:0] ST_TIMEOUT = 2'd2;
  localparam logic [ST_W-1:0] ST_ACKED   = 2'd3;

  // One stored table entry.
  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [ID_W-1:0]    id;
    logic [ST_W-1:0]    st;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

endpackage

FILE: hw/rtl/alert_ack_retransmit_table.sv
// Alert acknowledge and retransmit table: top level with the entry memory and its sequencer.
// Depends on aart_pkg for codes, widths and the entry record.
//
// Ordered table of pending alerts keyed by class and id. A command beat is taken only while
// the block is idle; the sequencer then walks the held entries one at a time through a single
// registered memory read port and one compare/subtract unit, each entry read in S_RD and then
// evaluated in S_EVAL. Clear stops walking at its match and then packs the later entries
// forward, each one read in S_SH_RD and written back one slot lower in S_SH_WR. A command
// produces one to MAX_RESULTS result beats, the final one marked by last; a stalled output
// holds the walk.
// The timeout register is written through the cfg channel and must only change while idle.
module alert_ack_retransmit_table
  import aart_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  // Command channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [CLASS_W-1:0]  msg_class,
  input  logic [ID_W-1:0]     msg_id,
  input  logic [TIME_W-1:0]   now_time,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STAT_W-1:0]   status,
  output logic [COUNT_W-1:0]  entry_count,
  output logic                has_item,
  output logic [SLOT_W-1:0]   slot_index,
  output logic [CLASS_W-1:0]  out_class,
  output logic [ID_W-1:0]     out_id,
  output logic                last,
  // Timeout register write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TIME_W-1:0]   cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_SH_RD = 3'd3;
  localparam logic [2:0] S_SH_WR = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]         state;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      held;
  logic [RES_W-1:0]   n_res;
  logic [CMD_W-1:0]   cmd_r;
  logic [CLASS_W-1:0] class_r;
  logic [ID_W-1:0]    id_r;
  logic [TIME_W-1:0]  now_r;
  logic [TIME_W-1:0]  ack_timeout;
  logic [STAT_W-1:0]  res_status;
  logic               ack_found;

  // Result held back one step so that the final beat can carry last.
  logic               pend_valid;
  logic [SLOT_W-1:0]  pend_slot;
  logic [CLASS_W-1:0] pend_class;
  logic [ID_W-1:0]    pend_id;

  // Entry memory with one write port and one registered read port.
  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  entry_t             wr_data;

  logic               in_take;
  logic               out_free;
  logic               out_load;
  logic [CW-1:0]      idx_inc;
  logic               walk_end;
  logic               match;
  logic               scan_send;
  logic               scan_age;
  logic               ack_hit;
  logic               new_res;
  logic               eval_go;
  logic [TIME_W-1:0]  age;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign idx_inc   = idx + CW'(1);
  assign walk_end  = (idx >= held);

  // The output register takes a new beat this cycle.
  assign out_load  = ((state == S_EVAL) && eval_go && new_res && pend_valid) ||
                     ((state == S_DONE) && out_free);

  // Evaluation of the entry just read: key match, send and aging decisions.
  always_comb begin
    age       = now_r - rd_data.stamp;
    match     = (rd_data.cls == class_r) && (rd_data.id == id_r);
    scan_send = (cmd_r == CMD_SCAN) && (n_res < RES_W'(MAX_RESULTS)) &&
                ((rd_data.st == ST_NEW) || (rd_data.st == ST_TIMEOUT));
    scan_age  = (cmd_r == CMD_SCAN) && (rd_data.st == ST_WAIT) && (age > ack_timeout);
    ack_hit   = (cmd_r == CMD_ACK) && match;
    new_res   = scan_send || (ack_hit && (n_res < RES_W'(MAX_RESULTS)));
    eval_go   = !(new_res && pend_valid && !out_free);
  end

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    unique case (state)
      S_RD: begin
        if (!walk_end) begin
          rd_en = 1'b1;
        end else if (cmd_r == CMD_RAISE) begin
          // No match found: append the new key behind the held entries.
          wr_en         = 1'b1;
          wr_addr       = held[AW-1:0];
          wr_data.cls   = class_r;
          wr_data.id    = id_r;
          wr_data.st    = ST_NEW;
          wr_data.stamp = now_r;
        end
      end
      S_EVAL: begin
        if (eval_go) begin
          if (scan_send) begin
            wr_en      = 1'b1;
            wr_data.st = ST_WAIT;
            if (rd_data.st == ST_TIMEOUT) begin
              wr_data.stamp = now_r;
            end
          end else if (scan_age) begin
            wr_en      = 1'b1;
            wr_data.st = ST_TIMEOUT;
          end else if (ack_hit) begin
            wr_en      = 1'b1;
            wr_data.st = ST_ACKED;
          end
        end
      end
      S_SH_RD: begin
        rd_en   = (idx_inc < held);
        rd_addr = idx_inc[AW-1:0];
      end
      S_SH_WR: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Entry memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Timeout register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ack_timeout <= cfg_data;
    end
  end

  // Sequencer, pending result and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            cmd_r      <= cmd;
            class_r    <= msg_class;
            id_r       <= msg_id;
            now_r      <= now_time;
            idx        <= '0;
            n_res      <= '0;
            ack_found  <= 1'b0;
            pend_valid <= 1'b0;
            if ((cmd == CMD_RAISE) && (held >= DEPTH_C)) begin
              res_status <= RES_FULL;
              state      <= S_DONE;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          if (walk_end) begin
            unique case (cmd_r)
              CMD_RAISE: begin
                held       <= held + CW'(1);
                res_status <= RES_OK;
              end
              CMD_SCAN:  res_status <= RES_OK;
              CMD_ACK:   res_status <= ack_found ? RES_OK : RES_NOTFOUND;
              default:   res_status <= RES_NOTFOUND;
            endcase
            state <= S_DONE;
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if ((cmd_r == CMD_RAISE) && match) begin
            // Key already present: nothing is added.
            res_status <= RES_OK;
            state      <= S_DONE;
          end else if ((cmd_r == CMD_CLEAR) && match) begin
            pend_valid <= 1'b1;
            pend_slot  <= SLOT_W'(idx);
            pend_class <= class_r;
            pend_id    <= id_r;
            state      <= S_SH_RD;
          end else if (eval_go) begin
            if (ack_hit) begin
              ack_found <= 1'b1;
            end
            if (new_res) begin
              // Hand the older pending result to the output, keep the new one back.
              if (pend_valid) begin
                out_valid   <= 1'b1;
                status      <= RES_OK;
                entry_count <= COUNT_W'(held);
                has_item    <= 1'b1;
                slot_index  <= pend_slot;
                out_class   <= pend_class;
                out_id      <= pend_id;
                last        <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_slot  <= SLOT_W'(idx);
              pend_class <= rd_data.cls;
              pend_id    <= rd_data.id;
              n_res      <= n_res + RES_W'(1);
            end
            idx   <= idx_inc;
            state <= S_RD;
          end
        end
        S_SH_RD: begin
          if (idx_inc < held) begin
            state <= S_SH_WR;
          end else begin
            held       <= held - CW'(1);
            res_status <= RES_OK;
            state      <= S_DONE;
          end
        end
        S_SH_WR: begin
          idx   <= idx_inc;
          state <= S_SH_RD;
        end
        S_DONE: begin
          // Final beat of the command.
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            entry_count <= COUNT_W'(held);
            has_item    <= pend_valid;
            slot_index  <= pend_valid ? pend_slot : '0;
            out_class   <= pend_valid ? pend_class : '0;
            out_id      <= pend_valid ? pend_id : '0;
            last        <= 1'b1;
            pend_valid  <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: test/tb_alert_ack_retransmit_table.sv
// Testbench for alert_ack_retransmit_table: directed table walk plus random command traffic,
// with every result beat checked against a built-in model of the pending-alert table.
// Depends on aart_pkg and alert_ack_retransmit_table only.
`timescale 1ns / 1ps

module tb_alert_ack_retransmit_table;
  import aart_pkg::*;

  localparam int DEPTH       = DEFAULT_DEPTH;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;
  localparam int POOL_SIZE   = 20;
  localparam int NUM_ROWS    = 20;

  // One expected or observed result beat.
  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
    logic               has;
    logic [SLOT_W-1:0]  slot;
    logic [CLASS_W-1:0] cls;
    logic [ID_W-1:0]    id;
    logic               last;
  } alert_result_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [CLASS_W-1:0] cls;
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  now;
    int                 reps;
    bit                 typed;
    logic [STAT_W-1:0]  t_status;
    logic [COUNT_W-1:0] t_count;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [CMD_W-1:0]   cmd;
  logic [CLASS_W-1:0] msg_class;
  logic [ID_W-1:0]    msg_id;
  logic [TIME_W-1:0]  now_time;
  logic               out_valid;
  logic               out_stall;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] entry_count;
  logic               has_item;
  logic [SLOT_W-1:0]  slot_index;
  logic [CLASS_W-1:0] out_class;
  logic [ID_W-1:0]    out_id;
  logic               last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [TIME_W-1:0]  cfg_data;

  // Typed expectation that travels with a directed beat.
  logic               row_typed;
  logic [STAT_W-1:0]  row_status;
  logic [COUNT_W-1:0] row_count;

  // Model of the alert table and its timeout register.
  logic [CLASS_W-1:0] tbl_cls   [DEPTH];
  logic [ID_W-1:0]    tbl_id    [DEPTH];
  logic [ST_W-1:0]    tbl_st    [DEPTH];
  logic [TIME_W-1:0]  tbl_stamp [DEPTH];
  int                 tbl_held   = 0;
  logic [TIME_W-1:0]  timeout_ms = TIMEOUT_RESET;

  alert_result_t      step_beats[$];
  alert_result_t      expected_alerts[$];

  int                 err_count   = 0;
  int                 idle_cycles = 0;
  bit                 hold_req    = 1'b0;
  bit                 rx_quiet    = 1'b0;
  bit                 tx_quiet    = 1'b0;
  logic [TIME_W-1:0]  clock_ms;
  logic [CLASS_W-1:0] pool_cls [POOL_SIZE];
  logic [ID_W-1:0]    pool_id  [POOL_SIZE];

  alert_ack_retransmit_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .msg_class  (msg_class),
    .msg_id     (msg_id),
    .now_time   (now_time),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .entry_count(entry_count),
    .has_item   (has_item),
    .slot_index (slot_index),
    .out_class  (out_class),
    .out_id     (out_id),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Count one mismatch and print it while fewer than 100 have been seen.
  task automatic report_error(input string msg);
    if (err_count < 100) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  function automatic int find_entry(input logic [CLASS_W-1:0] k_cls,
                                    input logic [ID_W-1:0] k_id);
    for (int i = 0; i < tbl_held; i++) begin
      if (tbl_cls[i] == k_cls && tbl_id[i] == k_id) return i;
    end
    return -1;
  endfunction

  // Build a result beat; the count is the table size at the moment of the call.
  function automatic alert_result_t make_beat(input logic [STAT_W-1:0] st, input logic has,
                                              input int slot, input logic [CLASS_W-1:0] k_cls,
                                              input logic [ID_W-1:0] k_id);
    alert_result_t r;
    r.status = st;
    r.count  = COUNT_W'(tbl_held);
    r.has    = has;
    r.slot   = has ? SLOT_W'(slot) : '0;
    r.cls    = has ? k_cls : '0;
    r.id     = has ? k_id : '0;
    r.last   = 1'b0;
    return r;
  endfunction

  // Apply one command to the table model and leave its result beats in step_beats.
  function automatic void predict_table_cmd(input logic [CMD_W-1:0] c,
                                            input logic [CLASS_W-1:0] k_cls,
                                            input logic [ID_W-1:0] k_id,
                                            input logic [TIME_W-1:0] now);
    int pos;
    logic [TIME_W-1:0] age;
    alert_result_t tail;
    step_beats.delete();
    case (c)
      CMD_RAISE: begin
        if (tbl_held >= DEPTH) begin
          step_beats.push_back(make_beat(RES_FULL, 1'b0, 0, '0, '0));
        end else begin
          // A key already held is left alone.
          if (find_entry(k_cls, k_id) < 0) begin
            tbl_cls[tbl_held]   = k_cls;
            tbl_id[tbl_held]    = k_id;
            tbl_st[tbl_held]    = ST_NEW;
            tbl_stamp[tbl_held] = now;
            tbl_held++;
          end
          step_beats.push_back(make_beat(RES_OK, 1'b0, 0, '0, '0));
        end
      end
      CMD_SCAN: begin
        for (int i = 0; i < tbl_held; i++) begin
          if (tbl_st[i] == ST_NEW || tbl_st[i] == ST_TIMEOUT) begin
            if (step_beats.size() < MAX_RESULTS) begin
              if (tbl_st[i] == ST_TIMEOUT) tbl_stamp[i] = now;
              tbl_st[i] = ST_WAIT;
              step_beats.push_back(make_beat(RES_OK, 1'b1, i, tbl_cls[i], tbl_id[i]));
            end
          end else if (tbl_st[i] == ST_WAIT) begin
            // Age wraps modulo 2^32.
            age = now - tbl_stamp[i];
            if (age > timeout_ms) tbl_st[i] = ST_TIMEOUT;
          end
        end
        if (step_beats.size() == 0) begin
          step_beats.push_back(make_beat(RES_OK, 1'b0, 0, '0, '0));
        end
      end
      CMD_ACK: begin
        for (int i = 0; i < tbl_held; i++) begin
          if (tbl_cls[i] == k_cls && tbl_id[i] == k_id) begin
            tbl_st[i] = ST_ACKED;
            if (step_beats.size() < MAX_RESULTS) begin
              step_beats.push_back(make_beat(RES_OK, 1'b1, i, k_cls, k_id));
            end
          end
        end
        if (step_beats.size() == 0) begin
          step_beats.push_back(make_beat(RES_NOTFOUND, 1'b0, 0, '0, '0));
        end
      end
      default: begin
        pos = find_entry(k_cls, k_id);
        if (pos < 0) begin
          step_beats.push_back(make_beat(RES_NOTFOUND, 1'b0, 0, '0, '0));
        end else begin
          // Later entries move forward by one slot.
          for (int i = pos; i + 1 < tbl_held; i++) begin
            tbl_cls[i]   = tbl_cls[i + 1];
            tbl_id[i]    = tbl_id[i + 1];
            tbl_st[i]    = tbl_st[i + 1];
            tbl_stamp[i] = tbl_stamp[i + 1];
          end
          tbl_held--;
          step_beats.push_back(make_beat(RES_OK, 1'b1, pos, k_cls, k_id));
        end
      end
    endcase
    tail = step_beats.pop_back();
    tail.last = 1'b1;
    step_beats.push_back(tail);
  endfunction

  // Predict on every accepted command, track register writes, check every result beat.
  always @(posedge clk) begin
    alert_result_t want;
    alert_result_t typed_beat;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_table_cmd(cmd, msg_class, msg_id, now_time);
        if (row_typed) begin
          typed_beat = '{status: row_status, count: row_count, has: 1'b0, slot: '0,
                         cls: '0, id: '0, last: 1'b1};
          step_beats.delete();
          step_beats.push_back(typed_beat);
        end
        foreach (step_beats[i]) expected_alerts.push_back(step_beats[i]);
      end
      if (cfg_valid && cfg_ready) begin
        timeout_ms = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_alerts.size() == 0) begin
          report_error($sformatf("result beat with nothing expected, status %0d id 0x%0h",
                                 status, out_id));
        end else begin
          want = expected_alerts.pop_front();
          check_field("status", 64'(status), 64'(want.status));
          check_field("entry_count", 64'(entry_count), 64'(want.count));
          check_field("has_item", 64'(has_item), 64'(want.has));
          check_field("slot_index", 64'(slot_index), 64'(want.slot));
          check_field("out_class", 64'(out_class), 64'(want.cls));
          check_field("out_id", out_id, want.id);
          check_field("last", 64'(last), 64'(want.last));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any accepted beat.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Result side stall pattern: random runs, a quiet mode, and one long hold-off on request.
  initial begin
    int n;
    int m;
    int r;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 12);
        r = $urandom_range(0, 99);
        if (r < 70) m = $urandom_range(1, 2);
        else if (r < 95) m = $urandom_range(3, 6);
        else m = $urandom_range(10, 40);
        out_stall <= 1'b0;
        repeat (n) @(posedge clk);
        out_stall <= 1'b1;
        repeat (m) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Offer one command beat and hold it until taken, then idle for a randomly picked gap.
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [CLASS_W-1:0] k_cls,
                          input logic [ID_W-1:0] k_id, input logic [TIME_W-1:0] now,
                          input bit typed, input logic [STAT_W-1:0] t_status,
                          input logic [COUNT_W-1:0] t_count);
    int gap;
    in_valid   <= 1'b1;
    cmd        <= c;
    msg_class  <= k_cls;
    msg_id     <= k_id;
    now_time   <= now;
    row_typed  <= typed;
    row_status <= t_status;
    row_count  <= t_count;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering commands and wait until every expected beat has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_alerts.size() != 0) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIME_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly keys from a small pool or already held, with some stray keys.
  task automatic run_random(input int count);
    logic [CMD_W-1:0]   c;
    logic [CLASS_W-1:0] k_cls;
    logic [ID_W-1:0]    k_id;
    int                 r;
    int                 j;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) c = CMD_RAISE;
      else if (r < 65) c = CMD_SCAN;
      else if (r < 80) c = CMD_ACK;
      else c = CMD_CLEAR;
      r = $urandom_range(0, 99);
      if ((c == CMD_ACK || c == CMD_CLEAR) && tbl_held > 0 && r < 70) begin
        j = $urandom_range(0, tbl_held - 1);
        k_cls = tbl_cls[j];
        k_id  = tbl_id[j];
      end else if (r < 88) begin
        j = $urandom_range(0, POOL_SIZE - 1);
        k_cls = pool_cls[j];
        k_id  = pool_id[j];
      end else begin
        k_cls = CLASS_W'($urandom_range(0, 255));
        k_id  = {$urandom, $urandom};
      end
      // Time mostly creeps forward, sometimes leaps anywhere.
      r = $urandom_range(0, 99);
      if (r < 80) clock_ms = clock_ms + TIME_W'($urandom_range(0, 300));
      else if (r < 95) clock_ms = clock_ms + TIME_W'($urandom_range(300, 3000));
      else clock_ms = $urandom;
      send_cmd(c, k_cls, k_id, clock_ms, 1'b0, RES_OK, '0);
    end
  endtask

  // Main sequence: reset, directed table, then random phases at several timeouts.
  initial begin
    dir_row_t rows[NUM_ROWS];
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    cmd        <= CMD_RAISE;
    msg_class  <= '0;
    msg_id     <= '0;
    now_time   <= '0;
    row_typed  <= 1'b0;
    row_status <= RES_OK;
    row_count  <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Empty table, first keys, duplicate key, aging at the timeout boundary and across
    // the time wrap, filling to the top, raises on a full table, a full-width scan.
    rows[0]  = '{CMD_SCAN,  8'h00, 64'h0, 32'h0, 1, 1'b1, RES_OK, 5'd0};
    rows[1]  = '{CMD_ACK,   8'h12, 64'h1234, 32'h0, 1, 1'b1, RES_NOTFOUND, 5'd0};
    rows[2]  = '{CMD_CLEAR, 8'h12, 64'h1234, 32'h0, 1, 1'b1, RES_NOTFOUND, 5'd0};
    rows[3]  = '{CMD_RAISE, 8'h00, 64'h0, 32'h0, 1, 1'b1, RES_OK, 5'd1};
    rows[4]  = '{CMD_RAISE, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1, 1'b1, RES_OK, 5'd2};
    rows[5]  = '{CMD_RAISE, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1, 1'b1, RES_OK, 5'd2};
    rows[6]  = '{CMD_SCAN,  8'h00, 64'h0, 32'd10, 1, 1'b0, RES_OK, 5'd0};
    rows[7]  = '{CMD_SCAN,  8'h00, 64'h0, 32'd1011, 1, 1'b0, RES_OK, 5'd0};
    rows[8]  = '{CMD_SCAN,  8'hAA, 64'h5555_AAAA_5555_AAAA, 32'hFFFF_FFFF, 1, 1'b0, RES_OK, 5'd0};
    rows[9]  = '{CMD_ACK,   8'h00, 64'h0, 32'h0, 1, 1'b0, RES_OK, 5'd0};
    rows[10] = '{CMD_SCAN,  8'h00, 64'h0, 32'd999, 1, 1'b0, RES_OK, 5'd0};
    rows[11] = '{CMD_SCAN,  8'h00, 64'h0, 32'd1000, 1, 1'b0, RES_OK, 5'd0};
    rows[12] = '{CMD_CLEAR, 8'h00, 64'h0, 32'h0, 1, 1'b0, RES_OK, 5'd0};
    rows[13] = '{CMD_RAISE, 8'hA5, 64'hA5A5_0000_0000_0000, 32'h400, 15, 1'b0, RES_OK, 5'd0};
    rows[14] = '{CMD_RAISE, 8'h33, 64'h1, 32'h480, 1, 1'b1, RES_FULL, 5'd16};
    rows[15] = '{CMD_RAISE, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h480, 1, 1'b1, RES_FULL, 5'd16};
    rows[16] = '{CMD_SCAN,  8'h00, 64'h0, 32'h500, 1, 1'b0, RES_OK, 5'd0};
    rows[17] = '{CMD_CLEAR, 8'hA5, 64'hA5A5_0000_0000_000E, 32'h500, 1, 1'b0, RES_OK, 5'd0};
    rows[18] = '{CMD_ACK,   8'hA5, 64'hA5A5_0000_0000_0003, 32'h500, 1, 1'b0, RES_OK, 5'd0};
    rows[19] = '{CMD_CLEAR, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h500, 1, 1'b0, RES_OK, 5'd0};

    foreach (rows[r]) begin
      for (int k = 0; k < rows[r].reps; k++) begin
        send_cmd(rows[r].cmd, rows[r].cls, rows[r].id + ID_W'(k), rows[r].now + TIME_W'(k),
                 rows[r].typed, rows[r].t_status, rows[r].t_count);
      end
    end
    drain();

    foreach (pool_cls[i]) begin
      pool_cls[i] = CLASS_W'($urandom_range(0, 255));
      pool_id[i]  = {$urandom, $urandom};
    end
    clock_ms = 32'hFFFF_F000;

    // Largest timeout, no idling on either side.
    write_timeout(32'hFFFF_FFFF);
    rx_quiet = 1'b1;
    tx_quiet = 1'b1;
    run_random(14);
    drain();

    // Zero timeout, opening with a long result-side hold-off while commands keep coming.
    write_timeout(32'h0);
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
    hold_req = 1'b1;
    run_random(16);
    drain();

    // Short random timeout.
    write_timeout(TIME_W'($urandom_range(20, 400)));
    run_random(18);
    drain();

    // Back to the reset timeout, with a full drain halfway through.
    write_timeout(TIMEOUT_RESET);
    run_random(9);
    drain();
    run_random(9);
    drain();

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
